// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, all disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Trigger implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/actr_pkg.sv =====
// ---------------------------------------------------------------------------
// actr_pkg
// Types, constants and round functions for the AES-128 counter-mode cipher.
// ---------------------------------------------------------------------------
package actr_pkg;

  typedef logic [127:0] blk_t;
  typedef logic [7:0]   byte_t;
  typedef logic [4:0]   cnt_t;

  localparam int   NumRounds  = 10;
  localparam cnt_t BlockBytes = 5'd16;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_KEY_HIGH      = 3'd0,
    REG_KEY_LOW       = 3'd1,
    REG_NONCE_HIGH    = 3'd2,
    REG_NONCE_LOW     = 3'd3,
    REG_START_COUNTER = 3'd4
  } reg_idx_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // Multiply by x in GF(2^8)
  function automatic byte_t xtime(input byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte j of a block, byte 0 in the top bits
  function automatic byte_t get_byte(input blk_t v, input int j);
    return v[127 - 8*j -: 8];
  endfunction

  // One key schedule step: round key k to round key k+1
  function automatic blk_t next_round_key(input blk_t rk, input byte_t rc);
    logic [31:0] w0, w1, w2, w3, tmp;
    w0  = rk[127:96];
    tmp = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    w0  = w0 ^ tmp;
    w1  = rk[95:64] ^ w0;
    w2  = rk[63:32] ^ w1;
    w3  = rk[31:0]  ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // One cipher round; the final round skips the column mix
  function automatic blk_t cipher_round(input blk_t s, input blk_t rk, input logic last);
    byte_t t [16];
    byte_t a0, a1, a2, a3;
    blk_t  r;
    for (int c = 0; c < 4; c++) begin
      for (int rw = 0; rw < 4; rw++) begin
        t[rw + 4*c] = SBOX[get_byte(s, rw + 4*((c + rw) & 3))];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        t[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        t[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        t[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        t[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    for (int j = 0; j < 16; j++) begin
      r[127 - 8*j -: 8] = t[j];
    end
    return r ^ rk;
  endfunction

endpackage

// ===== design/aes128_counter_mode_cipher.sv =====
// ---------------------------------------------------------------------------
// AES-128 counter-mode cipher
// Encrypts nonce || counter per block and XORs the keystream with the data.
//
//  Channel  Dir  Beat contents
//  s_axis   in   data block, valid byte count; tuser = start of message
//  m_axis   out  result block, valid byte count
//  cfg      in   register index and write data
//
// One block per cycle while the output is not stalled. Stages: an input
// stage with the first key addition, ten round stages each deriving its
// own round key, and the output register. Round keys move with the data.
// Reset clears the valid bits, the block counter and the configuration
// registers.
// A stalled output fills bubbles first; input stalls only when all stages
// are full.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module aes128_counter_mode_cipher import actr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // data_high, data_low, byte_count, pad
  input  logic         s_axis_tuser,  // start_message
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,  // result_high, result_low, result_count, pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [63:0] key_high, key_low, nonce_high;
  logic [31:0] nonce_low, start_counter, block_counter;

  logic in_beat, out_load;
  logic [NumRounds:0] load;
  logic [NumRounds:0] st_valid;
  blk_t st_state [NumRounds+1];
  blk_t st_key   [NumRounds+1];
  blk_t st_data  [NumRounds+1];
  cnt_t st_count [NumRounds+1];

  logic [31:0] ctr;
  cnt_t        in_count;
  blk_t        in_key, result;
  logic [127:0] res_blk;
  cnt_t        res_count;

  assign cfg_ready = 1'b1;
  assign in_beat   = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0; key_low <= '0; nonce_high <= '0;
      nonce_low <= '0; start_counter <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_HIGH:      key_high      <= cfg_data;
        REG_KEY_LOW:       key_low       <= cfg_data;
        REG_NONCE_HIGH:    nonce_high    <= cfg_data;
        REG_NONCE_LOW:     nonce_low     <= cfg_data[31:0];
        REG_START_COUNTER: start_counter <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Counter select and advance
  assign ctr = s_axis_tuser ? start_counter : block_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
    end else if (in_beat) begin
      block_counter <= ctr + 32'd1;
    end
  end

  // Stage load enables, collapsing bubbles
  assign out_load = !m_axis_tvalid || m_axis_tready;
  always_comb begin
    load[NumRounds] = !st_valid[NumRounds] || out_load;
    for (int i = NumRounds - 1; i >= 0; i--) begin
      load[i] = !st_valid[i] || load[i+1];
    end
  end
  assign s_axis_tready = load[0];

  // Input stage: clamp count, first key addition
  assign in_count = (s_axis_tdata[132:128] > BlockBytes) ? BlockBytes : s_axis_tdata[132:128];
  assign in_key   = {key_high, key_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (load[0]) begin
      st_valid[0] <= in_beat;
    end
    if (load[0]) begin
      st_state[0] <= {nonce_high, nonce_low, ctr} ^ in_key;
      st_key[0]   <= in_key;
      st_data[0]  <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
      st_count[0] <= in_count;
    end
  end

  // Round stages
  for (genvar k = 1; k <= NumRounds; k++) begin : g_round
    blk_t rk;
    assign rk = next_round_key(st_key[k-1], RCON[k-1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (load[k]) begin
        st_valid[k] <= st_valid[k-1];
      end
      if (load[k]) begin
        st_state[k] <= cipher_round(st_state[k-1], rk, k == NumRounds);
        st_key[k]   <= rk;
        st_data[k]  <= st_data[k-1];
        st_count[k] <= st_count[k-1];
      end
    end
  end

  // Keystream XOR, zero bytes past the count
  always_comb begin
    result = st_data[NumRounds] ^ st_state[NumRounds];
    for (int j = 0; j < 16; j++) begin
      if (5'(j) >= st_count[NumRounds]) begin
        result[127 - 8*j -: 8] = 8'h00;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= st_valid[NumRounds];
    end
    if (out_load) begin
      res_blk   <= result;
      res_count <= st_count[NumRounds];
    end
  end

  assign m_axis_tdata = {3'b000, res_count, res_blk[63:0], res_blk[127:64]};

  // Checks
  `ASSERT_NEXT(a_ctr_reload, clk, rst, in_beat && s_axis_tuser,
    block_counter == $past(start_counter) + 32'd1, "counter did not reload")
  `ASSERT_NEXT(a_ctr_step, clk, rst, in_beat && !s_axis_tuser,
    block_counter == $past(block_counter) + 32'd1, "counter did not advance")
  `ASSERT_NEXT(a_ctr_hold, clk, rst, !in_beat, $stable(block_counter),
    "counter moved without a beat")
  `ASSERT_ALWAYS(a_count_range, clk, rst, !m_axis_tvalid || res_count <= BlockBytes,
    "result count above sixteen")
  `ASSERT_ALWAYS(a_zero_count, clk, rst, !m_axis_tvalid || res_count != 5'd0 || res_blk == '0,
    "bytes past count not zero")

endmodule
